// ===== rtl/bvt_pkg.sv =====
// ----------------------------------------------------------------------------
// bvt_pkg
// shared types and constants of the byte vocabulary tokenizer
// ----------------------------------------------------------------------------
package bvt_pkg;

	localparam int ALPHABET_SIZE_DEF = 256;
	localparam int COUNT_W           = 9;

	typedef logic [7:0]         byte_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam byte_t UNKNOWN_CHAR = 8'd63;

	typedef enum logic [2:0] {
		REQ_BEGIN  = 3'd0,
		REQ_TRAIN  = 3'd1,
		REQ_FINISH = 3'd2,
		REQ_ENCODE = 3'd3,
		REQ_DECODE = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		KIND_COUNT  = 2'd0,
		KIND_ID     = 2'd1,
		KIND_CHAR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WALK,
		ST_LOOKUP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic  wr_en;
		logic  wr_data;
		byte_t wr_addr;
		logic  rd_en;
		byte_t rd_addr;
	} seen_ctl_t;

	typedef struct packed {
		logic  wr_en;
		byte_t b2i_wr_addr;
		byte_t b2i_wr_data;
		byte_t i2b_wr_addr;
		byte_t i2b_wr_data;
		logic  b2i_rd_en;
		byte_t b2i_rd_addr;
		logic  i2b_rd_en;
		byte_t i2b_rd_addr;
	} tbl_ctl_t;

endpackage

// ===== rtl/bvt_seen_map.sv =====
// ----------------------------------------------------------------------------
// bvt_seen_map
// presence bit per byte value, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bvt_seen_map #(
	parameter int ALPHABET_SIZE = bvt_pkg::ALPHABET_SIZE_DEF
) (
	input  logic               clk,
	input  bvt_pkg::seen_ctl_t ctl,
	output logic               rd_data
);

	localparam int IDX_W = $clog2(ALPHABET_SIZE);

	logic seen_mem [ALPHABET_SIZE];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			seen_mem[ctl.wr_addr[IDX_W-1:0]] <= ctl.wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= seen_mem[ctl.rd_addr[IDX_W-1:0]];
		end
	end

endmodule

// ===== rtl/bvt_tables.sv =====
// ----------------------------------------------------------------------------
// bvt_tables
// forward (byte to id) and reverse (id to byte) tables, registered reads
// ----------------------------------------------------------------------------
module bvt_tables #(
	parameter int ALPHABET_SIZE = bvt_pkg::ALPHABET_SIZE_DEF
) (
	input  logic              clk,
	input  bvt_pkg::tbl_ctl_t ctl,
	output bvt_pkg::byte_t    b2i_rd_data,
	output bvt_pkg::byte_t    i2b_rd_data
);

	localparam int IDX_W = $clog2(ALPHABET_SIZE);

	bvt_pkg::byte_t b2i_mem [ALPHABET_SIZE];
	bvt_pkg::byte_t i2b_mem [ALPHABET_SIZE];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			b2i_mem[ctl.b2i_wr_addr[IDX_W-1:0]] <= ctl.b2i_wr_data;
			i2b_mem[ctl.i2b_wr_addr[IDX_W-1:0]] <= ctl.i2b_wr_data;
		end
		if (ctl.b2i_rd_en) begin
			b2i_rd_data <= b2i_mem[ctl.b2i_rd_addr[IDX_W-1:0]];
		end
		if (ctl.i2b_rd_en) begin
			i2b_rd_data <= i2b_mem[ctl.i2b_rd_addr[IDX_W-1:0]];
		end
	end

endmodule

// ===== rtl/byte_vocabulary_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// byte_vocabulary_tokenizer_core
// packs the byte alphabet of a training text into dense token ids
// ----------------------------------------------------------------------------
// requests arrive on the in_valid / in_ready channel, results leave on the
// out_valid / out_ready channel through one output register
// one request is handled at a time; train gives no result
// begin clears the presence map in a pass over every byte value, in_ready is
// low until the pass ends
// encode and decode read the tables at the transfer; the result is loaded
// into the output register from the lookup state once the register is free
// an encode that cannot have an id gives nothing
// finish walks the presence map one byte value per cycle through the read
// latency, writing both tables; its result is loaded into the output register
// once the walk has drained and the register is free
// while a result waits in the output register, begin and train go on;
// a lookup or finish holds in its last state until the register frees
// reset starts the same clearing pass as begin, in_ready stays low until
// the pass ends; the tables are left unwritten
// ----------------------------------------------------------------------------
module byte_vocabulary_tokenizer_core #(
	parameter int ALPHABET_SIZE = bvt_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          req_type,
	input  logic [7:0]          text_byte,
	input  logic [8:0]          token_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          result_kind,
	output logic [7:0]          id_out,
	output logic [7:0]          char_out,
	output logic [8:0]          vocab_count
);

	localparam int IDX_W = $clog2(ALPHABET_SIZE);

	bvt_pkg::state_t    state_q, state_d;
	logic [IDX_W-1:0]   walk_q;
	logic [IDX_W-1:0]   walk_addr_s1;
	logic               walk_s1;
	bvt_pkg::count_t    count_q;
	logic               ids_ready_q;
	logic               is_decode_q;
	logic               hit_q;

	logic               out_valid_q;
	bvt_pkg::kind_t     kind_q;
	bvt_pkg::byte_t     id_q;
	bvt_pkg::byte_t     char_q;
	bvt_pkg::count_t    vcount_q;

	bvt_pkg::seen_ctl_t seen_ctl;
	bvt_pkg::tbl_ctl_t  tbl_ctl;
	logic               seen_rd;
	bvt_pkg::byte_t     b2i_rd_data;
	bvt_pkg::byte_t     i2b_rd_data;

	logic               in_xfer;
	logic               in_range;
	logic               dec_hit;
	logic               walk_last;
	logic               walk_wr;
	logic               lookup_hit;
	logic               out_free;
	logic               out_load;

	bvt_seen_map #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_seen (
		.clk    (clk),
		.ctl    (seen_ctl),
		.rd_data(seen_rd)
	);

	bvt_tables #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_tables (
		.clk        (clk),
		.ctl        (tbl_ctl),
		.b2i_rd_data(b2i_rd_data),
		.i2b_rd_data(i2b_rd_data)
	);

	assign in_ready   = (state_q == bvt_pkg::ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign in_range   = ({1'b0, text_byte} < bvt_pkg::count_t'(ALPHABET_SIZE));
	assign dec_hit    = (token_id < count_q);
	assign walk_last  = (walk_q == IDX_W'(ALPHABET_SIZE - 1));
	assign walk_wr    = walk_s1 && seen_rd;
	assign lookup_hit = is_decode_q || seen_rd;
	assign out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d              = state_q;
		seen_ctl             = '0;
		tbl_ctl              = '0;
		out_load             = 1'b0;
		seen_ctl.rd_addr     = text_byte;
		seen_ctl.wr_addr     = text_byte;
		tbl_ctl.b2i_rd_addr  = text_byte;
		tbl_ctl.i2b_rd_addr  = token_id[7:0];
		tbl_ctl.wr_en        = walk_wr;
		tbl_ctl.b2i_wr_addr  = bvt_pkg::byte_t'(walk_addr_s1);
		tbl_ctl.b2i_wr_data  = count_q[7:0];
		tbl_ctl.i2b_wr_addr  = count_q[7:0];
		tbl_ctl.i2b_wr_data  = bvt_pkg::byte_t'(walk_addr_s1);
		unique case (state_q)
			bvt_pkg::ST_IDLE: begin
				if (in_xfer) begin
					unique case (bvt_pkg::req_t'(req_type))
						bvt_pkg::REQ_BEGIN: begin
							state_d = bvt_pkg::ST_CLEAR;
						end
						bvt_pkg::REQ_TRAIN: begin
							seen_ctl.wr_en   = in_range;
							seen_ctl.wr_data = 1'b1;
						end
						bvt_pkg::REQ_FINISH: begin
							state_d = bvt_pkg::ST_WALK;
						end
						bvt_pkg::REQ_ENCODE: begin
							if (in_range && ids_ready_q) begin
								seen_ctl.rd_en    = 1'b1;
								tbl_ctl.b2i_rd_en = 1'b1;
								state_d           = bvt_pkg::ST_LOOKUP;
							end
						end
						bvt_pkg::REQ_DECODE: begin
							tbl_ctl.i2b_rd_en = dec_hit;
							state_d           = bvt_pkg::ST_LOOKUP;
						end
						default: begin
						end
					endcase
				end
			end
			bvt_pkg::ST_CLEAR: begin
				seen_ctl.wr_en   = 1'b1;
				seen_ctl.wr_addr = bvt_pkg::byte_t'(walk_q);
				seen_ctl.wr_data = 1'b0;
				if (walk_last) begin
					state_d = bvt_pkg::ST_IDLE;
				end
			end
			bvt_pkg::ST_WALK: begin
				seen_ctl.rd_en   = 1'b1;
				seen_ctl.rd_addr = bvt_pkg::byte_t'(walk_q);
				if (walk_last) begin
					state_d = bvt_pkg::ST_FINISH;
				end
			end
			bvt_pkg::ST_LOOKUP: begin
				if (!lookup_hit) begin
					state_d = bvt_pkg::ST_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = bvt_pkg::ST_IDLE;
				end
			end
			bvt_pkg::ST_FINISH: begin
				if (!walk_s1 && out_free) begin
					out_load = 1'b1;
					state_d  = bvt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bvt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q      <= '0;
			walk_s1     <= 1'b0;
			count_q     <= '0;
			ids_ready_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				unique case (bvt_pkg::req_t'(req_type))
					bvt_pkg::REQ_BEGIN: begin
						walk_q      <= '0;
						count_q     <= '0;
						ids_ready_q <= 1'b0;
					end
					bvt_pkg::REQ_TRAIN: begin
						if (in_range) begin
							ids_ready_q <= 1'b0;
						end
					end
					bvt_pkg::REQ_FINISH: begin
						count_q <= '0;
						walk_q  <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == bvt_pkg::ST_CLEAR || state_q == bvt_pkg::ST_WALK) begin
				walk_q <= walk_q + 1'b1;
			end
			walk_s1 <= (state_q == bvt_pkg::ST_WALK);
			if (walk_wr) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == bvt_pkg::ST_WALK && walk_last) begin
				ids_ready_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// lookup bookkeeping and result payload
	always_ff @(posedge clk) begin
		walk_addr_s1 <= walk_q;
		if (in_xfer) begin
			is_decode_q <= (bvt_pkg::req_t'(req_type) == bvt_pkg::REQ_DECODE);
			hit_q       <= dec_hit;
		end
		if (out_load) begin
			vcount_q <= count_q;
			if (state_q == bvt_pkg::ST_FINISH) begin
				kind_q <= bvt_pkg::KIND_COUNT;
				id_q   <= '0;
				char_q <= '0;
			end else if (is_decode_q) begin
				kind_q <= bvt_pkg::KIND_CHAR;
				id_q   <= '0;
				char_q <= hit_q ? i2b_rd_data : bvt_pkg::UNKNOWN_CHAR;
			end else begin
				kind_q <= bvt_pkg::KIND_ID;
				id_q   <= b2i_rd_data;
				char_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign id_out      = id_q;
	assign char_out    = char_q;
	assign vocab_count = vcount_q;

endmodule
